[hw/rtl/accumulator_cpu_16bit_top_defines.svh]
// Assertion macros used by the accumulator processor RTL.
`ifndef ACCUMULATOR_CPU_16BIT_TOP_DEFINES_SVH
`define ACCUMULATOR_CPU_16BIT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ACPU_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ACPU_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/acpu16_pkg.sv]
// Types, codes and the microcode table of the accumulator processor.
package acpu16_pkg;

    localparam int ADDR_W = 13;
    localparam int WORD_W = 16;
    localparam int UPC_W  = 3;

    typedef enum logic [1:0] {
        CMD_STEP   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_SET_IP = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_STORE = 3'd3,
        OP_JNEG  = 3'd4,
        OP_JPOS  = 3'd5,
        OP_JZERO = 3'd6,
        OP_JMP   = 3'd7
    } op_t;

    // Memory address source.
    typedef enum logic [1:0] {
        ASEL_IP    = 2'd0,
        ASEL_FETCH = 2'd1,
        ASEL_IR    = 2'd2,
        ASEL_HOST  = 2'd3
    } asel_t;

    localparam logic [UPC_W-1:0] U_IDLE  = 3'd0;
    localparam logic [UPC_W-1:0] U_FETCH = 3'd1;
    localparam logic [UPC_W-1:0] U_EXEC  = 3'd2;
    localparam logic [UPC_W-1:0] U_WR    = 3'd3;
    localparam logic [UPC_W-1:0] U_RD0   = 3'd4;
    localparam logic [UPC_W-1:0] U_RD1   = 3'd5;
    localparam logic [UPC_W-1:0] U_SIP   = 3'd6;

    typedef struct packed {
        asel_t            asel;
        logic             mem_we;
        logic             wsel_host;
        logic             ir_ld;
        logic             ip_inc;
        logic             ip_host;
        logic             exec;
        logic             rd_cap;
        logic             finish;
        logic             dispatch;
        logic [UPC_W-1:0] next_upc;
    } ctl_t;

    function automatic ctl_t ucode_rom(input logic [UPC_W-1:0] upc);
        ctl_t c;
        c = '0;
        c.asel = ASEL_IP;
        c.next_upc = U_IDLE;
        case (upc)
            U_IDLE:
            begin
                c.dispatch = 1'b1;
            end
            U_FETCH:
            begin
                c.asel = ASEL_FETCH;
                c.ir_ld = 1'b1;
                c.ip_inc = 1'b1;
                c.next_upc = U_EXEC;
            end
            U_EXEC:
            begin
                c.asel = ASEL_IR;
                c.exec = 1'b1;
                c.finish = 1'b1;
            end
            U_WR:
            begin
                c.asel = ASEL_HOST;
                c.mem_we = 1'b1;
                c.wsel_host = 1'b1;
                c.finish = 1'b1;
            end
            U_RD0:
            begin
                c.asel = ASEL_HOST;
                c.next_upc = U_RD1;
            end
            U_RD1:
            begin
                c.asel = ASEL_HOST;
                c.rd_cap = 1'b1;
                c.finish = 1'b1;
            end
            U_SIP:
            begin
                c.ip_host = 1'b1;
                c.finish = 1'b1;
            end
            default:
            begin
                c.next_upc = U_IDLE;
            end
        endcase
        return c;
    endfunction

    // Entry point of the microprogram for each command.
    function automatic logic [UPC_W-1:0] ucode_entry(input cmd_t cmd);
        logic [UPC_W-1:0] e;
        case (cmd)
            CMD_STEP:   e = U_FETCH;
            CMD_WRITE:  e = U_WR;
            CMD_READ:   e = U_RD0;
            CMD_SET_IP: e = U_SIP;
            default:    e = U_IDLE;
        endcase
        return e;
    endfunction

endpackage

[hw/rtl/accumulator_cpu_16bit_top.sv]
// 16-bit accumulator processor with its own word memory, run by a small microcode sequencer.
//
// Input channel (in_valid, in_stall, cmd, addr, wdata): each transaction is one command:
// run one instruction, write a memory word, read a memory word, or set the instruction
// pointer. Output channel (out_valid, out_stall, acc_value, ip_value, ir_value, read_data):
// exactly one transaction per command, carrying the processor state after that command.
// The block takes one command at a time. An instruction runs as three microcode steps:
// the idle step already presents IP to the memory, so fetch data arrives with the next step,
// which latches IR and issues the operand read, and the last step executes. A read runs the
// idle step, RD0 and RD1, and a write or a set-IP goes from the idle step straight to its
// last step. The single memory port, one access per cycle, sets this step sequence.
// An output register holds the finished result, so a new command is accepted while the
// result waits. If the receiver stalls and the next command reaches its last step, the
// sequencer waits on that step without changing any state until the output is free.
// Reset clears the accumulator, IP, IR and the sequencer; memory contents are undefined
// until written, and words at MEM_WORDS and above read as zero and ignore writes.
`include "accumulator_cpu_16bit_top_defines.svh"

module accumulator_cpu_16bit_top
    import acpu16_pkg::*;
#(
    parameter int ADDR_BITS = 13,
    parameter int MEM_WORDS = 8192
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        cmd,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WORD_W-1:0] wdata,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WORD_W-1:0] acc_value,
    output logic [ADDR_W-1:0] ip_value,
    output logic [WORD_W-1:0] ir_value,
    output logic [WORD_W-1:0] read_data
);

    localparam int RAM_AW = $clog2(MEM_WORDS);
    localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((ADDR_W + 1)'(1) << ADDR_BITS) - 1'b1;
    localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W + 1)'(MEM_WORDS);

    // Sequencer and architectural state.
    logic [UPC_W-1:0]  upc_reg, upc_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [ADDR_W-1:0] ip_reg, ip_next;
    logic [WORD_W-1:0] ir_reg, ir_next;
    logic              rd_ok_reg;

    // Host command operands, latched on acceptance.
    logic [ADDR_W-1:0] haddr_reg;
    logic [WORD_W-1:0] hwdata_reg;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_acc_reg;
    logic [ADDR_W-1:0] out_ip_reg;
    logic [WORD_W-1:0] out_ir_reg;
    logic [WORD_W-1:0] out_rd_reg;

    ctl_t              cw;
    logic              accept;
    logic              advance;
    logic              fin_fire;
    logic [WORD_W-1:0] rdata;
    logic [WORD_W-1:0] mdata;
    logic [ADDR_W-1:0] mem_a;
    logic              mem_ok;
    logic              ram_we;
    logic [WORD_W-1:0] ram_wdata;
    op_t               op;
    logic [ADDR_W-1:0] ir_target;
    logic              acc_neg;
    logic              acc_zero;
    logic              take;

    assign cw = ucode_rom(upc_reg);

    // The idle step is the only one that takes a new command.
    assign in_stall = !cw.dispatch;
    assign accept   = in_valid && !in_stall;

    // The last step of a command waits while the previous result is still held.
    assign advance  = !(cw.finish && out_valid_reg && out_stall);
    assign fin_fire = cw.finish && advance;

    // Words outside the memory read as zero.
    assign mdata = rd_ok_reg ? rdata : '0;

    assign op        = op_t'(ir_reg[WORD_W-1:ADDR_W]);
    assign ir_target = ir_reg[ADDR_W-1:0] & ADDR_MASK;
    assign acc_neg   = acc_reg[WORD_W-1];
    assign acc_zero  = (acc_reg == '0);

    always_comb
    begin
        case (cw.asel)
            ASEL_IP:    mem_a = ip_reg;
            ASEL_FETCH: mem_a = mdata[ADDR_W-1:0] & ADDR_MASK;
            ASEL_IR:    mem_a = ir_target;
            ASEL_HOST:  mem_a = haddr_reg & ADDR_MASK;
            default:    mem_a = ip_reg;
        endcase
    end

    assign mem_ok    = ({1'b0, mem_a} < MEM_LIMIT);
    assign ram_we    = advance && mem_ok && (cw.mem_we || (cw.exec && (op == OP_STORE)));
    assign ram_wdata = cw.wsel_host ? hwdata_reg : acc_reg;

    acpu16_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (mem_a[RAM_AW-1:0]),
        .wdata (ram_wdata),
        .rdata (rdata)
    );

    // Branch condition uses the accumulator from before this instruction.
    always_comb
    begin
        case (op)
            OP_JNEG:  take = acc_neg;
            OP_JPOS:  take = !acc_neg && !acc_zero;
            OP_JZERO: take = acc_zero;
            OP_JMP:   take = 1'b1;
            default:  take = 1'b0;
        endcase
    end

    always_comb
    begin
        upc_next = upc_reg;
        acc_next = acc_reg;
        ip_next  = ip_reg;
        ir_next  = ir_reg;
        if (cw.dispatch)
        begin
            upc_next = accept ? ucode_entry(cmd_t'(cmd)) : U_IDLE;
        end
        else if (advance)
        begin
            upc_next = cw.next_upc;
            if (cw.ir_ld)
            begin
                ir_next = mdata;
            end
            if (cw.ip_inc)
            begin
                ip_next = (ip_reg + 1'b1) & ADDR_MASK;
            end
            if (cw.ip_host)
            begin
                ip_next = haddr_reg & ADDR_MASK;
            end
            if (cw.exec)
            begin
                case (op)
                    OP_LOAD: acc_next = mdata;
                    OP_ADD:  acc_next = acc_reg + mdata;
                    OP_SUB:  acc_next = acc_reg - mdata;
                    default: acc_next = acc_reg;
                endcase
                if (take)
                begin
                    ip_next = ir_target;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= U_IDLE;
            acc_reg       <= '0;
            ip_reg        <= '0;
            ir_reg        <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            acc_reg       <= acc_next;
            ip_reg        <= ip_next;
            ir_reg        <= ir_next;
            rd_ok_reg     <= mem_ok;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            haddr_reg  <= addr;
            hwdata_reg <= wdata;
        end
        if (fin_fire)
        begin
            out_acc_reg <= acc_next;
            out_ip_reg  <= ip_next;
            out_ir_reg  <= ir_next;
            out_rd_reg  <= cw.rd_cap ? mdata : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign acc_value = out_acc_reg;
    assign ip_value  = out_ip_reg;
    assign ir_value  = out_ir_reg;
    assign read_data = out_rd_reg;

    `ACPU_ASSERT_NXT(a_accept_busy, accept, in_stall, "command accepted but sequencer idle")
    `ACPU_ASSERT_IMP(a_out_from_finish, $rose(out_valid_reg), $past(fin_fire), "result without finish")
    `ACPU_ASSERT_IMP(a_ip_masked, 1'b1, ((ip_reg & ~ADDR_MASK) == '0), "IP outside address range")
    `ACPU_ASSERT_IMP(a_no_idle_write, cw.dispatch, !ram_we, "memory written while idle")

endmodule

[hw/rtl/acpu16_ram.sv]
// Generic single-port RAM with a registered read.
module acpu16_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[addr] <= wdata;
        end
        rdata_reg <= ram_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule
